// File: rtl/adsr_pkg.sv
// ----------------------------------------------------------------------------
// adsr_pkg
// Shared widths, codes and types for the ADSR envelope gain stage.
// ----------------------------------------------------------------------------
package adsr_pkg;

  // Level is unsigned with LEVEL_FRAC_BITS fraction bits; 1.0 needs one more bit
  localparam int LEVEL_FRAC_BITS = 23;
  localparam int LEVEL_W         = LEVEL_FRAC_BITS + 1;
  localparam int SAMPLE_WIDTH    = 24;
  localparam int CMD_W           = 2;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 24;

  localparam logic [LEVEL_W-1:0] LVL_ONE = LEVEL_W'(1) << LEVEL_FRAC_BITS;

  typedef logic [LEVEL_W-1:0]             level_t;
  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE   = 2'd0,
    CMD_NOTE_ON  = 2'd1,
    CMD_NOTE_OFF = 2'd2,
    CMD_UNUSED   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4
  } phase_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENV_ENABLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_STEP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_STEP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN_LEVEL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_STEP  = 3'd4;

endpackage

// File: rtl/adsr_if.sv
// ----------------------------------------------------------------------------
// adsr_in_if / adsr_out_if / adsr_cfg_if
// Valid/ready channels of the ADSR envelope gain stage.
// ----------------------------------------------------------------------------
interface adsr_in_if;
  logic                 valid;
  logic                 ready;
  adsr_pkg::cmd_t       cmd;
  adsr_pkg::sample_t    sample_in;

  modport source (output valid, output cmd, output sample_in, input ready);
  modport sink   (input valid, input cmd, input sample_in, output ready);
endinterface

interface adsr_out_if;
  logic                 valid;
  logic                 ready;
  adsr_pkg::sample_t    sample_out;
  logic                 voice_active;
  adsr_pkg::phase_t     env_phase;

  modport source (output valid, output sample_out, output voice_active,
                  output env_phase, input ready);
  modport sink   (input valid, input sample_out, input voice_active,
                  input env_phase, output ready);
endinterface

interface adsr_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [adsr_pkg::CFG_IDX_W-1:0]        index;
  logic [adsr_pkg::CFG_DATA_W-1:0]       data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/adsr_envelope_gain_core.sv
// ----------------------------------------------------------------------------
// adsr_envelope_gain_core
// Linear ADSR gain stage: note events drive the envelope, samples are scaled.
// ----------------------------------------------------------------------------
// One result word per input word, one word per cycle sustained while the
// output side is not stalled. A word accepted by the core updates the
// envelope state and lands in the stage register; the multiply stage then
// loads the output register from it once that register is free, and the
// result is held there until the output side takes it. The
// envelope state register is the only loop, so back-to-back words see each
// other's updates. Configuration writes are always taken (cfg ready is held
// high) and should only be made while idle.
module adsr_envelope_gain_core (
  input  logic              clk,
  input  logic              rst_n,
  adsr_in_if.sink           in_if,
  adsr_out_if.source        out_if,
  adsr_cfg_if.sink          cfg_if
);
  import adsr_pkg::*;

  typedef enum logic [1:0] {
    MODE_ZERO,
    MODE_PASS,
    MODE_SCALE
  } mode_t;

  localparam int PROD_W = SAMPLE_WIDTH + LEVEL_W + 1;

  // configuration
  logic   env_enable_r;
  level_t attack_step_r;
  level_t decay_step_r;
  level_t sustain_level_r;
  level_t release_step_r;

  // envelope state
  phase_t phase_r, phase_nxt;
  level_t level_r, level_nxt;
  logic   note_active_r, note_active_nxt;

  // stage register
  logic    s1_valid_r;
  sample_t s1_sample_r;
  level_t  s1_level_r;
  mode_t   s1_mode_r, mode_nxt;
  logic    s1_active_r;
  phase_t  s1_phase_r;

  // output register
  logic    out_valid_r;
  sample_t out_sample_r;
  logic    out_active_r;
  phase_t  out_phase_r;

  logic   in_acc;
  logic   out_load;
  logic   in_rdy;
  level_t sus_lvl;
  level_t att_st;
  level_t rel_st;
  logic [LEVEL_W:0] att_sum;
  level_t dec_diff;
  level_t rel_diff;
  logic signed [PROD_W-1:0] prod;
  sample_t scaled;

  assign out_load = !out_valid_r || out_if.ready;
  assign in_rdy   = !s1_valid_r || out_load;
  assign in_acc   = in_if.valid && in_rdy;

  assign in_if.ready  = in_rdy;
  assign cfg_if.ready = 1'b1;

  // Clamped settings
  assign sus_lvl = (sustain_level_r > LVL_ONE) ? LVL_ONE : sustain_level_r;
  assign att_st  = (attack_step_r == '0) ? level_t'(1) :
                   (attack_step_r > LVL_ONE) ? LVL_ONE : attack_step_r;
  assign rel_st  = (release_step_r == '0) ? level_t'(1) :
                   (release_step_r > LVL_ONE) ? LVL_ONE : release_step_r;

  assign att_sum  = {1'b0, level_r} + {1'b0, att_st};
  // decrements saturate at zero
  assign dec_diff = (level_r > decay_step_r) ? level_r - decay_step_r : '0;
  assign rel_diff = (level_r > rel_st) ? level_r - rel_st : '0;

  always_comb begin
    phase_nxt       = phase_r;
    level_nxt       = level_r;
    note_active_nxt = note_active_r;
    mode_nxt        = MODE_ZERO;
    case (in_if.cmd)
      CMD_SAMPLE: begin
        if (env_enable_r || phase_r == PH_RELEASE) begin
          mode_nxt = MODE_SCALE;
          case (phase_r)
            PH_ATTACK: begin
              if (att_sum >= {1'b0, LVL_ONE}) begin
                level_nxt = LVL_ONE;
                phase_nxt = (decay_step_r != '0) ? PH_DECAY : PH_SUSTAIN;
              end else begin
                level_nxt = att_sum[LEVEL_W-1:0];
              end
            end
            PH_DECAY: begin
              if (decay_step_r == '0 || dec_diff <= sus_lvl) begin
                level_nxt = sus_lvl;
                phase_nxt = PH_SUSTAIN;
              end else begin
                level_nxt = dec_diff;
              end
            end
            PH_RELEASE: begin
              level_nxt = rel_diff;
              if (rel_diff == '0) begin
                phase_nxt       = PH_IDLE;
                note_active_nxt = 1'b0;
              end
            end
            default: ;
          endcase
        end else begin
          mode_nxt = MODE_PASS;
        end
      end
      CMD_NOTE_ON: begin
        note_active_nxt = 1'b1;
        if (env_enable_r) begin
          phase_nxt = PH_ATTACK;
        end else begin
          level_nxt = LVL_ONE;
          phase_nxt = PH_SUSTAIN;
        end
      end
      CMD_NOTE_OFF: begin
        if (env_enable_r) begin
          phase_nxt = PH_RELEASE;
        end else begin
          note_active_nxt = 1'b0;
          phase_nxt       = PH_IDLE;
          level_nxt       = '0;
        end
      end
      default: ;
    endcase
  end

  // Signed product, then arithmetic shift by the fraction bits
  assign prod   = PROD_W'(s1_sample_r) * $signed({1'b0, s1_level_r});
  assign scaled = prod[LEVEL_FRAC_BITS +: SAMPLE_WIDTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      env_enable_r    <= 1'b0;
      attack_step_r   <= LVL_ONE;
      decay_step_r    <= '0;
      sustain_level_r <= LVL_ONE;
      release_step_r  <= LVL_ONE;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        CFG_ENV_ENABLE:    env_enable_r    <= cfg_if.data[0];
        CFG_ATTACK_STEP:   attack_step_r   <= level_t'(cfg_if.data);
        CFG_DECAY_STEP:    decay_step_r    <= level_t'(cfg_if.data);
        CFG_SUSTAIN_LEVEL: sustain_level_r <= level_t'(cfg_if.data);
        CFG_RELEASE_STEP:  release_step_r  <= level_t'(cfg_if.data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      level_r       <= '0;
      note_active_r <= 1'b0;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_r       <= phase_nxt;
        level_r       <= level_nxt;
        note_active_r <= note_active_nxt;
      end
      if (in_rdy) begin
        s1_valid_r <= in_acc;
      end
      if (out_load) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sample_r <= in_if.sample_in;
      s1_level_r  <= level_nxt;
      s1_mode_r   <= mode_nxt;
      s1_active_r <= note_active_nxt || (phase_nxt == PH_RELEASE);
      s1_phase_r  <= phase_nxt;
    end
    if (out_load && s1_valid_r) begin
      case (s1_mode_r)
        MODE_PASS:  out_sample_r <= s1_sample_r;
        MODE_SCALE: out_sample_r <= scaled;
        default:    out_sample_r <= '0;
      endcase
      out_active_r <= s1_active_r;
      out_phase_r  <= s1_phase_r;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.sample_out   = out_sample_r;
  assign out_if.voice_active = out_active_r;
  assign out_if.env_phase    = out_phase_r;

endmodule

// File: rtl/adsr_chk.sv
// ----------------------------------------------------------------------------
// adsr_chk
// Port-level checks for the ADSR envelope gain stage, bound to the top level.
// ----------------------------------------------------------------------------
module adsr_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [adsr_pkg::SAMPLE_WIDTH-1:0] out_sample,
  input logic                              out_active,
  input logic [2:0]                        out_phase
);
  import adsr_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample)
      && $stable(out_active) && $stable(out_phase))
    else $error("result word changed while stalled");

  // voice is sounding exactly when the envelope is not idle
  a_active_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_active == (out_phase != PH_IDLE)))
    else $error("voice_active disagrees with env_phase");

  // an accepted word reaches the output when the output side is not blocked
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 (out_ready || !out_valid) |=> out_valid)
    else $error("accepted word did not reach the output");

endmodule

bind adsr_envelope_gain_core adsr_chk u_adsr_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_if.valid),
  .in_ready   (in_if.ready),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .out_sample (out_if.sample_out),
  .out_active (out_if.voice_active),
  .out_phase  (out_if.env_phase)
);

// File: test/adsr_envelope_gain_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsr_envelope_gain_core_tb
// Drives note events and audio words through the envelope gain stage under
// bursty input and a stalling output, predicts every result word from a
// behavioural envelope model and checks them in order, field by field.
// ----------------------------------------------------------------------------
module adsr_envelope_gain_core_tb;
  import adsr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned RAND_PHASES = 13;
  localparam int unsigned PHASE_WORDS = 120;
  // index with no register behind it; writes are ignored
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;

  localparam sample_t SMP_MAX = 24'sh7FFFFF;
  localparam sample_t SMP_MIN = 24'sh800000;

  typedef struct {
    sample_t smp;
    logic    act;
    phase_t  ph;
  } gain_result_t;

  class adsr_scoreboard;
    bit          en;
    logic [23:0] atk;
    logic [23:0] dcy;
    logic [23:0] sus_lvl;
    logic [23:0] rel;
    phase_t      ph;
    logic [31:0] lvl;
    bit          held;
    gain_result_t pending_gain_results[$];
    int          errors;

    function new();
      en      = 1'b0;
      atk     = LVL_ONE;
      dcy     = '0;
      sus_lvl = LVL_ONE;
      rel     = LVL_ONE;
      ph      = PH_IDLE;
      lvl     = '0;
      held    = 1'b0;
      errors  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        CFG_ENV_ENABLE:    en = d[0];
        CFG_ATTACK_STEP:   atk = d;
        CFG_DECAY_STEP:    dcy = d;
        CFG_SUSTAIN_LEVEL: sus_lvl = d;
        CFG_RELEASE_STEP:  rel = d;
        default: ;
      endcase
    endfunction

    function logic [31:0] clamp_step(logic [23:0] s);
      if (s == 0) return 32'd1;
      if (s > LVL_ONE) return 32'(LVL_ONE);
      return 32'(s);
    endfunction

    function void advance_env();
      logic [31:0] sus;
      logic [31:0] st;
      sus = (sus_lvl > LVL_ONE) ? 32'(LVL_ONE) : 32'(sus_lvl);
      case (ph)
        PH_ATTACK: begin
          lvl = lvl + clamp_step(atk);
          if (lvl >= LVL_ONE) begin
            lvl = LVL_ONE;
            if (dcy != 0) ph = PH_DECAY;
            else ph = PH_SUSTAIN;
          end
        end
        PH_DECAY: begin
          if (dcy == 0) begin
            lvl = sus;
            ph  = PH_SUSTAIN;
          end else begin
            lvl = (lvl > dcy) ? lvl - dcy : 32'd0;
            if (lvl <= sus) begin
              lvl = sus;
              ph  = PH_SUSTAIN;
            end
          end
        end
        PH_RELEASE: begin
          st  = clamp_step(rel);
          lvl = (lvl > st) ? lvl - st : 32'd0;
          if (lvl == 0) begin
            ph   = PH_IDLE;
            held = 1'b0;
          end
        end
        default: ;
      endcase
    endfunction

    // floor of sample * level / 1.0
    function sample_t scaled(sample_t s);
      longint prod;
      prod = longint'(s) * longint'(lvl);
      return sample_t'(prod >>> LEVEL_FRAC_BITS);
    endfunction

    function void take_word(cmd_t c, sample_t s);
      gain_result_t r;
      r.smp = '0;
      case (c)
        CMD_SAMPLE: begin
          if (en || ph == PH_RELEASE) begin
            advance_env();
            r.smp = scaled(s);
          end else begin
            r.smp = s;
          end
        end
        CMD_NOTE_ON: begin
          held = 1'b1;
          if (en) begin
            ph = PH_ATTACK;
          end else begin
            lvl = LVL_ONE;
            ph  = PH_SUSTAIN;
          end
        end
        CMD_NOTE_OFF: begin
          if (en) begin
            ph = PH_RELEASE;
          end else begin
            held = 1'b0;
            ph   = PH_IDLE;
            lvl  = '0;
          end
        end
        default: ;
      endcase
      r.act = held || (ph == PH_RELEASE);
      r.ph  = ph;
      pending_gain_results.push_back(r);
    endfunction

    function void check_word(sample_t s, logic act, phase_t p);
      gain_result_t r;
      if (pending_gain_results.size() == 0) begin
        $display("%0t: result word with none expected (sample %0d)", $time, s);
        errors++;
        return;
      end
      r = pending_gain_results.pop_front();
      if (s !== r.smp) begin
        $display("%0t: sample_out expected %0d actual %0d", $time, r.smp, s);
        errors++;
      end
      if (act !== r.act) begin
        $display("%0t: voice_active expected %0b actual %0b", $time, r.act, act);
        errors++;
      end
      if (p !== r.ph) begin
        $display("%0t: env_phase expected %0d actual %0d", $time, r.ph, p);
        errors++;
      end
    endfunction

    function bit drained();
      return pending_gain_results.size() == 0;
    endfunction
  endclass

  logic clk;
  logic rst_n;

  adsr_in_if  in_if();
  adsr_out_if out_if();
  adsr_cfg_if cfg_if();

  adsr_envelope_gain_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  adsr_scoreboard sb = new();

  int unsigned cycle_count     = 0;
  int unsigned holds_requested = 0;
  int unsigned holds_served    = 0;
  int unsigned hold_left       = 0;
  int unsigned sink_mode       = 0;
  int unsigned mode_left       = 0;
  int unsigned burst_left      = 0;
  bit          gaps_on         = 1'b1;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("adsr_envelope_gain_core_tb NOT OK");
      $finish;
    end
  end

  // result side: check accepted words, stall on a pattern of its own
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1)
        sb.check_word(out_if.sample_out, out_if.voice_active, out_if.env_phase);
      if (holds_served != holds_requested) begin
        holds_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          sink_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        case (sink_mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= 1'($urandom_range(0, 1));
          2: out_if.ready <= ($urandom_range(0, 3) == 0);
          default: out_if.ready <= (cycle_count % 5) < 3;
        endcase
      end
    end
  end

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 15))
      0: return SMP_MAX;
      1: return SMP_MIN;
      2: return '0;
      3: return '1;
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] pick_step();
    case ($urandom_range(0, 15))
      0: return 24'd0;
      1: return 24'd1;
      2: return LVL_ONE;
      3: return 24'hFFFFFF;
      default: return 24'(LVL_ONE / $urandom_range(1, 40)) + 24'($urandom_range(0, 1023));
    endcase
  endfunction

  function automatic logic [23:0] pick_sustain();
    case ($urandom_range(0, 7))
      0: return 24'd0;
      1: return LVL_ONE;
      2: return 24'hFFFFFF;
      3: return 24'($urandom);
      default: return 24'($urandom_range(0, LVL_ONE));
    endcase
  endfunction

  // offer one input word; sender works in bursts with gaps between them
  task automatic offer(cmd_t c, sample_t s);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_if.valid     <= 1'b1;
    in_if.cmd       <= c;
    in_if.sample_in <= s;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    sb.take_word(c, s);
  endtask

  // hold the sender until every expected word has come back
  task automatic drain();
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (!sb.drained()) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    sb.write_reg(idx, d);
  endtask

  task automatic end_cfg();
    cfg_if.valid <= 1'b0;
  endtask

  task automatic random_config();
    logic [23:0] en_word;
    en_word = {23'($urandom), $urandom_range(0, 3) != 0};
    drain();
    write_reg(CFG_ENV_ENABLE, en_word);
    write_reg(CFG_ATTACK_STEP, pick_step());
    write_reg(CFG_DECAY_STEP, ($urandom_range(0, 3) == 0) ? 24'd0 : pick_step());
    write_reg(CFG_SUSTAIN_LEVEL, pick_sustain());
    write_reg(CFG_RELEASE_STEP, pick_step());
    if ($urandom_range(0, 3) == 0)
      write_reg(CFG_NO_REG, 24'($urandom));
    end_cfg();
  endtask

  task automatic random_sequence(output int unsigned n);
    int unsigned k;
    int unsigned m;
    n = 0;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        k = $urandom_range(1, 40);
        m = $urandom_range(1, 30);
        offer(CMD_NOTE_ON, rand_sample());
        repeat (k) offer(CMD_SAMPLE, rand_sample());
        offer(CMD_NOTE_OFF, rand_sample());
        repeat (m) offer(CMD_SAMPLE, rand_sample());
        n = k + m + 2;
      end
      6, 7: begin
        k = $urandom_range(1, 30);
        offer(CMD_NOTE_ON, rand_sample());
        repeat (k) offer(CMD_SAMPLE, rand_sample());
        n = k + 1;
      end
      default: begin
        // noise: any command, unused one included
        k = $urandom_range(1, 8);
        repeat (k) offer(cmd_t'($urandom_range(0, 3)), rand_sample());
        n = k;
      end
    endcase
  endtask

  initial begin
    int unsigned n;
    int unsigned words;
    in_if.valid     <= 1'b0;
    in_if.cmd       <= CMD_SAMPLE;
    in_if.sample_in <= '0;
    cfg_if.valid    <= 1'b0;
    cfg_if.index    <= CFG_ENV_ENABLE;
    cfg_if.data     <= '0;
    rst_n           <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // envelope off after reset: words pass through, notes switch at once
    offer(CMD_SAMPLE, SMP_MAX);
    offer(CMD_SAMPLE, SMP_MIN);
    offer(CMD_UNUSED, '1);
    offer(CMD_NOTE_ON, '0);
    offer(CMD_SAMPLE, '1);
    offer(CMD_NOTE_OFF, SMP_MAX);

    // oversized attack step, decay overshoots sustain, release saturates
    drain();
    write_reg(CFG_ENV_ENABLE, 24'd1);
    write_reg(CFG_ATTACK_STEP, 24'hFFFFFF);
    write_reg(CFG_DECAY_STEP, 24'h300000);
    write_reg(CFG_SUSTAIN_LEVEL, 24'h100000);
    write_reg(CFG_RELEASE_STEP, 24'h0C0000);
    end_cfg();
    offer(CMD_NOTE_ON, '0);
    offer(CMD_SAMPLE, SMP_MAX);
    offer(CMD_SAMPLE, SMP_MIN);
    offer(CMD_SAMPLE, '1);
    offer(CMD_SAMPLE, 24'sd1);
    offer(CMD_SAMPLE, SMP_MAX);
    offer(CMD_NOTE_OFF, '0);
    offer(CMD_SAMPLE, SMP_MIN);
    offer(CMD_SAMPLE, SMP_MAX);

    // no decay, sustain above 1.0, retrigger while sounding, full release step
    drain();
    write_reg(CFG_ATTACK_STEP, 24'h500000);
    write_reg(CFG_DECAY_STEP, 24'd0);
    write_reg(CFG_SUSTAIN_LEVEL, 24'hFFFFFF);
    write_reg(CFG_RELEASE_STEP, 24'hFFFFFF);
    end_cfg();
    offer(CMD_NOTE_ON, '0);
    offer(CMD_SAMPLE, SMP_MAX);
    offer(CMD_SAMPLE, SMP_MIN);
    offer(CMD_NOTE_ON, '0);
    offer(CMD_SAMPLE, SMP_MIN);
    offer(CMD_NOTE_OFF, '0);
    offer(CMD_SAMPLE, SMP_MAX);

    // decay step cleared while in decay: level jumps to sustain
    drain();
    write_reg(CFG_ATTACK_STEP, LVL_ONE);
    write_reg(CFG_DECAY_STEP, 24'h100000);
    write_reg(CFG_SUSTAIN_LEVEL, 24'd0);
    end_cfg();
    offer(CMD_NOTE_ON, '0);
    offer(CMD_SAMPLE, SMP_MAX);
    drain();
    write_reg(CFG_DECAY_STEP, 24'd0);
    end_cfg();
    offer(CMD_SAMPLE, SMP_MIN);

    for (int unsigned p = 0; p < RAND_PHASES; p++) begin
      random_config();
      gaps_on = (p % 4) != 1;
      if (p == 2 || p == 7 || p == 11)
        holds_requested <= holds_requested + 1;
      words = 0;
      while (words < PHASE_WORDS) begin
        random_sequence(n);
        words += n;
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.drained()) begin
      $display("adsr_envelope_gain_core_tb OK");
    end else begin
      $display("adsr_envelope_gain_core_tb NOT OK");
    end
    $finish;
  end

endmodule
